@@ hdl/cau_pkg.sv @@
package cau_pkg;

    localparam int DW    = 32;
    localparam int FB    = 16;
    localparam int PW    = 2 * DW;
    localparam int SW    = PW + 1;
    localparam int XW    = PW + 2;
    localparam int CW    = DW + FB + 4;
    localparam int ZW    = 34;
    localparam int TW    = 36;
    localparam int NIT   = DW;
    localparam int CSTEPS = 31;
    localparam int RSH   = 30 - FB;

    localparam logic [2:0] MODE_ADD   = 3'd0;
    localparam logic [2:0] MODE_SUB   = 3'd1;
    localparam logic [2:0] MODE_MUL   = 3'd2;
    localparam logic [2:0] MODE_DIV   = 3'd3;
    localparam logic [2:0] MODE_MAG   = 3'd4;
    localparam logic [2:0] MODE_PHASE = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_UNDEF = 2'd2;

    localparam logic signed [DW-1:0] SMAX_D = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [XW-1:0] SMAX_X = {{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [XW-1:0] SMIN_X = ~SMAX_X;

    localparam logic signed [TW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [TW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [TW-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic [TW-1:0] ROUND_ADD = TW'(1) << (RSH - 1);
    localparam logic [TW-1:0] LIM_FRAC  = (TW'(TWO_PI_Q30) + ROUND_ADD) >> RSH;

    typedef struct packed {
        logic [2:0]           mode;
        logic signed [DW-1:0] a_re;
        logic signed [DW-1:0] a_im;
        logic signed [DW-1:0] b_re;
        logic signed [DW-1:0] b_im;
        logic signed [DW-1:0] phase_offset;
    } in_t;

    typedef struct packed {
        logic signed [DW-1:0] result_re;
        logic signed [DW-1:0] result_im;
        logic [1:0]           status;
    } out_t;

    typedef struct packed {
        logic [2:0]           mode;
        logic                 are_pos;
        logic                 are_neg;
        logic                 aim_pos;
        logic                 aim_neg;
        logic                 b_zero;
        logic signed [DW-1:0] off;
        logic signed [DW-1:0] lin_re;
        logic signed [DW-1:0] lin_im;
        logic                 lin_sat;
        logic signed [PW-1:0] p_rr;
        logic signed [PW-1:0] p_ii;
        logic signed [PW-1:0] p_ri;
        logic signed [PW-1:0] p_ir;
        logic [PW-1:0]        sq_br;
        logic [PW-1:0]        sq_bi;
        logic [PW-1:0]        sq_ar;
        logic [PW-1:0]        sq_ai;
        logic signed [SW-1:0] sum_re;
        logic signed [SW-1:0] sum_im;
        logic [PW-1:0]        den;
        logic [PW-1:0]        sq_n;
        logic [PW-1:0]        dm_re;
        logic [PW-1:0]        dm_im;
        logic                 dneg_re;
        logic                 dneg_im;
        logic [PW-1:0]        rem_re;
        logic [PW-1:0]        rem_im;
        logic [DW-1:0]        q_re;
        logic [DW-1:0]        q_im;
        logic                 big_re;
        logic                 big_im;
        logic [PW-1:0]        sq_res;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [ZW-1:0] cz;
    } pipe_t;

    typedef struct packed {
        logic                 phase;
        logic                 undef;
        logic                 sat;
        logic                 clamp;
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic [TW-1:0]        th;
        logic signed [DW-1:0] off;
    } post_t;

    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] r;
        unique case (i)
            0:       r = ZW'(843314857);
            1:       r = ZW'(497837829);
            2:       r = ZW'(263043837);
            3:       r = ZW'(133525159);
            4:       r = ZW'(67021687);
            5:       r = ZW'(33543516);
            6:       r = ZW'(16775851);
            7:       r = ZW'(8388437);
            8:       r = ZW'(4194283);
            9:       r = ZW'(2097149);
            10:      r = ZW'(1048576);
            default: r = ZW'(1) << (30 - i);
        endcase
        return r;
    endfunction

    function automatic logic sat_ovf(input logic signed [XW-1:0] v);
        return (v > SMAX_X) || (v < SMIN_X);
    endfunction

    function automatic logic signed [DW-1:0] sat_clip(input logic signed [XW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > SMAX_X) begin
            r = SMAX_D;
        end else if (v < SMIN_X) begin
            r = ~SMAX_D;
        end else begin
            r = DW'(v);
        end
        return r;
    endfunction

    function automatic logic div_ovf(input logic [DW-1:0] q, input logic neg, input logic big);
        logic [DW:0] lim;
        lim = {1'b0, SMAX_D} + (DW+1)'(neg);
        return big || ({1'b0, q} > lim);
    endfunction

    function automatic logic signed [DW-1:0] div_val(input logic [DW-1:0] q, input logic neg,
                                                     input logic big);
        logic [DW:0] lim;
        logic [DW:0] mag;
        lim = {1'b0, SMAX_D} + (DW+1)'(neg);
        mag = (big || ({1'b0, q} > lim)) ? lim : {1'b0, q};
        return neg ? DW'(-mag) : DW'(mag);
    endfunction

endpackage

@@ hdl/complex_arithmetic_unit_top.sv @@
// throughput: one request per clock cycle; stalls hold only the stages that carry data
// the 32-stage divide, square root and cordic section sets the pipeline length
// reset: aresetn (synchronous, active low) clears every stage valid bit
// data registers are not reset
module complex_arithmetic_unit_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cau_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output cau_pkg::out_t m_payload
);

    localparam int NS     = cau_pkg::NIT + 6;
    localparam int ST_ABS = 3;

    logic [NS-1:0]  vld_reg;
    logic [NS-1:0]  vld_next;
    logic [NS-1:0]  vld_prev;
    logic [NS-1:0]  en;

    cau_pkg::in_t   in_reg;
    cau_pkg::pipe_t pipe_reg  [1:NS-3];
    cau_pkg::pipe_t pipe_next [1:NS-3];
    cau_pkg::post_t post_reg;
    cau_pkg::post_t post_next;
    cau_pkg::out_t  out_reg;
    cau_pkg::out_t  out_next;

    // stall chain
    assign en[NS-1] = !vld_reg[NS-1] || m_ready;
    for (genvar k = 0; k < NS - 1; k++) begin : g_en
        assign en[k] = !vld_reg[k] || en[k+1];
    end

    assign vld_prev = {vld_reg[NS-2:0], s_valid};
    assign vld_next = (en & vld_prev) | (~en & vld_reg);

    assign s_ready   = en[0];
    assign m_valid   = vld_reg[NS-1];
    assign m_payload = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            in_reg <= s_payload;
        end
        for (int k = 1; k <= NS - 3; k++) begin
            if (en[k]) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
        if (en[NS-2]) begin
            post_reg <= post_next;
        end
        if (en[NS-1]) begin
            out_reg <= out_next;
        end
    end

    // products, add and subtract, cordic start
    always_comb begin
        cau_pkg::pipe_t p;
        logic signed [cau_pkg::DW:0] sr;
        logic signed [cau_pkg::DW:0] si;
        logic signed [cau_pkg::CW-1:0] x0;
        logic signed [cau_pkg::CW-1:0] y0;
        p = '0;
        p.mode    = in_reg.mode;
        p.are_neg = in_reg.a_re[cau_pkg::DW-1];
        p.are_pos = !in_reg.a_re[cau_pkg::DW-1] && (in_reg.a_re != '0);
        p.aim_neg = in_reg.a_im[cau_pkg::DW-1];
        p.aim_pos = !in_reg.a_im[cau_pkg::DW-1] && (in_reg.a_im != '0);
        p.b_zero  = (in_reg.b_re == '0) && (in_reg.b_im == '0);
        p.off     = in_reg.phase_offset;
        if (in_reg.mode == cau_pkg::MODE_SUB) begin
            sr = (cau_pkg::DW+1)'(in_reg.a_re) - (cau_pkg::DW+1)'(in_reg.b_re);
            si = (cau_pkg::DW+1)'(in_reg.a_im) - (cau_pkg::DW+1)'(in_reg.b_im);
        end else begin
            sr = (cau_pkg::DW+1)'(in_reg.a_re) + (cau_pkg::DW+1)'(in_reg.b_re);
            si = (cau_pkg::DW+1)'(in_reg.a_im) + (cau_pkg::DW+1)'(in_reg.b_im);
        end
        p.lin_re  = cau_pkg::sat_clip(cau_pkg::XW'(sr));
        p.lin_im  = cau_pkg::sat_clip(cau_pkg::XW'(si));
        p.lin_sat = cau_pkg::sat_ovf(cau_pkg::XW'(sr)) || cau_pkg::sat_ovf(cau_pkg::XW'(si));
        p.p_rr  = cau_pkg::PW'(in_reg.a_re) * cau_pkg::PW'(in_reg.b_re);
        p.p_ii  = cau_pkg::PW'(in_reg.a_im) * cau_pkg::PW'(in_reg.b_im);
        p.p_ri  = cau_pkg::PW'(in_reg.a_re) * cau_pkg::PW'(in_reg.b_im);
        p.p_ir  = cau_pkg::PW'(in_reg.a_im) * cau_pkg::PW'(in_reg.b_re);
        p.sq_br = cau_pkg::PW'(in_reg.b_re) * cau_pkg::PW'(in_reg.b_re);
        p.sq_bi = cau_pkg::PW'(in_reg.b_im) * cau_pkg::PW'(in_reg.b_im);
        p.sq_ar = cau_pkg::PW'(in_reg.a_re) * cau_pkg::PW'(in_reg.a_re);
        p.sq_ai = cau_pkg::PW'(in_reg.a_im) * cau_pkg::PW'(in_reg.a_im);
        x0 = cau_pkg::CW'(in_reg.a_re) <<< cau_pkg::FB;
        y0 = cau_pkg::CW'(in_reg.a_im) <<< cau_pkg::FB;
        if (in_reg.a_re[cau_pkg::DW-1]) begin
            p.cx = -x0;
            p.cy = -y0;
        end else begin
            p.cx = x0;
            p.cy = y0;
        end
        pipe_next[1] = p;
    end

    // product sums
    always_comb begin
        cau_pkg::pipe_t p;
        logic signed [cau_pkg::SW-1:0] mr;
        logic signed [cau_pkg::SW-1:0] mi;
        p  = pipe_reg[1];
        mr = cau_pkg::SW'(p.p_rr) - cau_pkg::SW'(p.p_ii);
        mi = cau_pkg::SW'(p.p_ri) + cau_pkg::SW'(p.p_ir);
        if (p.mode == cau_pkg::MODE_MUL) begin
            p.lin_re  = cau_pkg::sat_clip(cau_pkg::XW'(mr >>> cau_pkg::FB));
            p.lin_im  = cau_pkg::sat_clip(cau_pkg::XW'(mi >>> cau_pkg::FB));
            p.lin_sat = cau_pkg::sat_ovf(cau_pkg::XW'(mr >>> cau_pkg::FB))
                     || cau_pkg::sat_ovf(cau_pkg::XW'(mi >>> cau_pkg::FB));
        end
        p.sum_re = cau_pkg::SW'(p.p_rr) + cau_pkg::SW'(p.p_ii);
        p.sum_im = cau_pkg::SW'(p.p_ir) - cau_pkg::SW'(p.p_ri);
        p.den    = p.sq_br + p.sq_bi;
        p.sq_n   = p.sq_ar + p.sq_ai;
        pipe_next[2] = p;
    end

    // numerator magnitudes
    always_comb begin
        cau_pkg::pipe_t p;
        p = pipe_reg[2];
        p.dneg_re = p.sum_re[cau_pkg::SW-1];
        p.dneg_im = p.sum_im[cau_pkg::SW-1];
        p.dm_re   = cau_pkg::PW'(p.dneg_re ? -p.sum_re : p.sum_re);
        p.dm_im   = cau_pkg::PW'(p.dneg_im ? -p.sum_im : p.sum_im);
        p.rem_re  = p.dm_re >> cau_pkg::FB;
        p.rem_im  = p.dm_im >> cau_pkg::FB;
        p.q_re    = '0;
        p.q_im    = '0;
        p.big_re  = 1'b0;
        p.big_im  = 1'b0;
        p.sq_res  = '0;
        p.cz      = '0;
        pipe_next[ST_ABS] = p;
    end

    // divide, square root and cordic steps, one per stage (the last stage does no cordic step)
    for (genvar j = 0; j < cau_pkg::NIT; j++) begin : g_iter
        localparam int K = ST_ABS + 1 + j;
        logic fb_re;
        logic fb_im;
        logic big_re_w;
        logic big_im_w;

        if (j < cau_pkg::FB) begin : g_feed
            assign fb_re = pipe_reg[K-1].dm_re[cau_pkg::FB-1-j];
            assign fb_im = pipe_reg[K-1].dm_im[cau_pkg::FB-1-j];
        end else begin : g_nofeed
            assign fb_re = 1'b0;
            assign fb_im = 1'b0;
        end

        if (j == 0) begin : g_big
            assign big_re_w = {cau_pkg::FB'(0), pipe_reg[K-1].dm_re}
                           >= {pipe_reg[K-1].den, cau_pkg::FB'(0)};
            assign big_im_w = {cau_pkg::FB'(0), pipe_reg[K-1].dm_im}
                           >= {pipe_reg[K-1].den, cau_pkg::FB'(0)};
        end else begin : g_keep
            assign big_re_w = pipe_reg[K-1].big_re;
            assign big_im_w = pipe_reg[K-1].big_im;
        end

        always_comb begin
            cau_pkg::pipe_t p;
            logic [cau_pkg::PW:0] tr;
            logic [cau_pkg::PW:0] ti;
            logic [cau_pkg::PW:0] den_x;
            logic [cau_pkg::PW-1:0] sbit;
            logic [cau_pkg::PW-1:0] strial;
            logic signed [cau_pkg::CW-1:0] dx;
            logic signed [cau_pkg::CW-1:0] dy;
            p      = pipe_reg[K-1];
            den_x  = {1'b0, p.den};
            tr     = {p.rem_re, fb_re};
            ti     = {p.rem_im, fb_im};
            p.big_re = big_re_w;
            p.big_im = big_im_w;
            if (tr >= den_x) begin
                p.rem_re = cau_pkg::PW'(tr - den_x);
                p.q_re   = {p.q_re[cau_pkg::DW-2:0], 1'b1};
            end else begin
                p.rem_re = tr[cau_pkg::PW-1:0];
                p.q_re   = {p.q_re[cau_pkg::DW-2:0], 1'b0};
            end
            if (ti >= den_x) begin
                p.rem_im = cau_pkg::PW'(ti - den_x);
                p.q_im   = {p.q_im[cau_pkg::DW-2:0], 1'b1};
            end else begin
                p.rem_im = ti[cau_pkg::PW-1:0];
                p.q_im   = {p.q_im[cau_pkg::DW-2:0], 1'b0};
            end
            sbit   = cau_pkg::PW'(1) << (cau_pkg::PW - 2 - 2 * j);
            strial = p.sq_res + sbit;
            if (p.sq_n >= strial) begin
                p.sq_n   = p.sq_n - strial;
                p.sq_res = (p.sq_res >> 1) + sbit;
            end else begin
                p.sq_res = p.sq_res >> 1;
            end
            dx = p.cy >>> j;
            dy = p.cx >>> j;
            if (j < cau_pkg::CSTEPS) begin
                if (!p.cy[cau_pkg::CW-1] && (p.cy != '0)) begin
                    p.cx = p.cx + dx;
                    p.cy = p.cy - dy;
                    p.cz = p.cz + cau_pkg::atan_q30(j);
                end else begin
                    p.cx = p.cx - dx;
                    p.cy = p.cy + dy;
                    p.cz = p.cz - cau_pkg::atan_q30(j);
                end
            end
            pipe_next[K] = p;
        end
    end

    // per-mode results and phase angle
    always_comb begin
        cau_pkg::pipe_t p;
        logic signed [cau_pkg::ZW-1:0] zf;
        logic signed [cau_pkg::TW-1:0] th;
        logic a_zero;
        p         = pipe_reg[NS-3];
        a_zero    = !(p.are_pos || p.are_neg || p.aim_pos || p.aim_neg);
        post_next = '0;
        post_next.off   = p.off;
        post_next.clamp = p.are_pos && p.aim_neg;
        zf = p.cz;
        if (p.are_pos && p.aim_pos && zf[cau_pkg::ZW-1]) begin
            zf = '0;
        end
        if (p.are_pos && p.aim_neg && !zf[cau_pkg::ZW-1]) begin
            zf = '1;
        end
        if (!p.aim_pos && !p.aim_neg) begin
            th = p.are_pos ? {cau_pkg::TW{1'b0}} : cau_pkg::PI_Q30;
        end else if (!p.are_pos && !p.are_neg) begin
            th = p.aim_pos ? cau_pkg::HALF_PI_Q30 : cau_pkg::PI_Q30 + cau_pkg::HALF_PI_Q30;
        end else begin
            th = (p.are_neg ? cau_pkg::PI_Q30 : {cau_pkg::TW{1'b0}}) + cau_pkg::TW'(zf);
            if (th[cau_pkg::TW-1]) begin
                th = th + cau_pkg::TWO_PI_Q30;
            end
        end
        post_next.th = th;
        unique case (p.mode)
            cau_pkg::MODE_ADD, cau_pkg::MODE_SUB, cau_pkg::MODE_MUL: begin
                post_next.re  = p.lin_re;
                post_next.im  = p.lin_im;
                post_next.sat = p.lin_sat;
            end
            cau_pkg::MODE_DIV: begin
                post_next.undef = p.b_zero;
                post_next.re    = cau_pkg::div_val(p.q_re, p.dneg_re, p.big_re);
                post_next.im    = cau_pkg::div_val(p.q_im, p.dneg_im, p.big_im);
                post_next.sat   = cau_pkg::div_ovf(p.q_re, p.dneg_re, p.big_re)
                               || cau_pkg::div_ovf(p.q_im, p.dneg_im, p.big_im);
            end
            cau_pkg::MODE_MAG: begin
                if (p.sq_res > cau_pkg::PW'(cau_pkg::SMAX_D)) begin
                    post_next.re  = cau_pkg::SMAX_D;
                    post_next.sat = 1'b1;
                end else begin
                    post_next.re  = cau_pkg::DW'(p.sq_res);
                end
            end
            cau_pkg::MODE_PHASE: begin
                post_next.phase = 1'b1;
                post_next.undef = a_zero;
            end
            default: begin
                post_next.undef = 1'b1;
            end
        endcase
    end

    // phase rounding and offset, output select
    always_comb begin
        logic [cau_pkg::TW-1:0] tq;
        logic signed [cau_pkg::XW-1:0] ph;
        tq = (post_reg.th + cau_pkg::ROUND_ADD) >> cau_pkg::RSH;
        if (post_reg.clamp && (tq >= cau_pkg::LIM_FRAC)) begin
            tq = cau_pkg::LIM_FRAC - cau_pkg::TW'(1);
        end
        ph = cau_pkg::XW'(tq) + cau_pkg::XW'(post_reg.off);
        out_next = '0;
        if (post_reg.undef) begin
            out_next.status = cau_pkg::ST_UNDEF;
        end else if (post_reg.phase) begin
            out_next.result_re = cau_pkg::sat_clip(ph);
            out_next.status    = cau_pkg::sat_ovf(ph) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end else begin
            out_next.result_re = post_reg.re;
            out_next.result_im = post_reg.im;
            out_next.status    = post_reg.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
    end

endmodule

@@ dv/complex_arithmetic_unit_top_tb.sv @@
`timescale 1ns / 100ps

module complex_arithmetic_unit_top_tb;

    typedef struct {
        cau_pkg::in_t  req;
        bit            fixed;
        cau_pkg::out_t want;
    } vector_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    cau_pkg::in_t  s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    cau_pkg::out_t m_payload;

    cau_pkg::out_t result_q[$];
    vector_t vectors[$];
    int      mismatches = 0;
    bit      no_gaps = 1'b0;

    localparam longint ONE   = 65536;
    localparam longint S_MAX = 64'sd2147483647;
    localparam longint S_MIN = -64'sd2147483648;

    complex_arithmetic_unit_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic longint clamp_word(logic signed [65:0] v, inout logic s);
        if (v > S_MAX) begin
            s = 1'b1;
            return S_MAX;
        end
        if (v < S_MIN) begin
            s = 1'b1;
            return S_MIN;
        end
        return longint'(v);
    endfunction

    function automatic longint q30_round(longint v);
        return (v + (64'sd1 << (29 - cau_pkg::FB))) >>> (30 - cau_pkg::FB);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bit_w;
        res = '0;
        bit_w = 64'd1 << 62;
        while (bit_w > n) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (n >= res + bit_w) begin
                n = n - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic longint phase_angle(longint re, longint im);
        longint x, y, z, base, th, tq, lim, ang, dx, dy;
        longint atans[11];
        atans = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                  16775851, 8388437, 4194283, 2097149, 1048576};
        if (im == 0) return (re > 0) ? 64'sd0 : q30_round(longint'(cau_pkg::PI_Q30));
        if (re == 0) begin
            return q30_round(im > 0 ? longint'(cau_pkg::HALF_PI_Q30)
                                    : longint'(cau_pkg::PI_Q30)
                                      + longint'(cau_pkg::HALF_PI_Q30));
        end
        x = re * 65536;
        y = im * 65536;
        z = 0;
        base = 0;
        if (re < 0) begin
            x = -x;
            y = -y;
            base = longint'(cau_pkg::PI_Q30);
        end
        for (int i = 0; i < 31; i++) begin
            ang = (i <= 10) ? atans[i] : (64'sd1 << (30 - i));
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx;
                y -= dy;
                z += ang;
            end else begin
                x -= dx;
                y += dy;
                z -= ang;
            end
        end
        if (re > 0 && im > 0 && z < 0) z = 0;
        if (re > 0 && im < 0 && z >= 0) z = -1;
        th = base + z;
        if (th < 0) th += longint'(cau_pkg::TWO_PI_Q30);
        tq = q30_round(th);
        lim = q30_round(longint'(cau_pkg::TWO_PI_Q30));
        if (re > 0 && im < 0 && tq >= lim) tq = lim - 1;
        return tq;
    endfunction

    function automatic longint quotient(logic signed [65:0] num, logic [63:0] den,
                                        inout logic s);
        logic        neg;
        logic [63:0] mag;
        logic [127:0] q;
        logic [127:0] lim;
        neg = num < 0;
        mag = neg ? 64'(-num) : 64'(num);
        q = ({64'd0, mag} << cau_pkg::FB) / {64'd0, den};
        lim = neg ? 128'd2147483648 : 128'd2147483647;
        if (q > lim) begin
            s = 1'b1;
            q = lim;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic cau_pkg::out_t alu_result(cau_pkg::in_t r);
        longint ar, ai, br, bi, rr, ri;
        logic signed [65:0] p, q;
        logic [63:0] den;
        logic s, undef;
        cau_pkg::out_t o;
        ar = r.a_re;
        ai = r.a_im;
        br = r.b_re;
        bi = r.b_im;
        rr = 0;
        ri = 0;
        s = 1'b0;
        undef = 1'b0;
        unique case (r.mode)
            cau_pkg::MODE_ADD: begin
                rr = clamp_word(ar + br, s);
                ri = clamp_word(ai + bi, s);
            end
            cau_pkg::MODE_SUB: begin
                rr = clamp_word(ar - br, s);
                ri = clamp_word(ai - bi, s);
            end
            cau_pkg::MODE_MUL: begin
                p = ar * br;
                q = ai * bi;
                rr = clamp_word((p - q) >>> cau_pkg::FB, s);
                p = ar * bi;
                q = ai * br;
                ri = clamp_word((p + q) >>> cau_pkg::FB, s);
            end
            cau_pkg::MODE_DIV: begin
                den = 64'(br * br) + 64'(bi * bi);
                if (den == 0) begin
                    undef = 1'b1;
                end else begin
                    p = ar * br;
                    q = ai * bi;
                    rr = quotient(p + q, den, s);
                    p = ai * br;
                    q = ar * bi;
                    ri = quotient(p - q, den, s);
                end
            end
            cau_pkg::MODE_MAG: begin
                den = int_sqrt(64'(ar * ar) + 64'(ai * ai));
                if (den > 64'(S_MAX)) begin
                    s = 1'b1;
                    den = 64'(S_MAX);
                end
                rr = longint'(den);
            end
            cau_pkg::MODE_PHASE: begin
                if (ar == 0 && ai == 0) begin
                    undef = 1'b1;
                end else begin
                    p = phase_angle(ar, ai);
                    q = longint'(r.phase_offset);
                    rr = clamp_word(p + q, s);
                end
            end
            default: undef = 1'b1;
        endcase
        o.result_re = undef ? '0 : 32'(rr);
        o.result_im = undef ? '0 : 32'(ri);
        o.status = undef ? cau_pkg::ST_UNDEF : (s ? cau_pkg::ST_SAT : cau_pkg::ST_OK);
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_operand();
        unique case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return 32'($urandom_range(0, 2097152)) - 32'd1048576;
            7: begin
                unique case ($urandom_range(0, 4))
                    0:       return 32'h7fffffff;
                    1:       return 32'h80000000;
                    2:       return 32'hffffffff;
                    3:       return 32'h00010000;
                    default: return 32'h00000001;
                endcase
            end
            8:       return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("mismatch %0s: got %0d, expected %0d", field, got, want);
        mismatches++;
    endtask

    task automatic add_vector(logic [2:0] mode, longint ar, longint ai, longint br,
                              longint bi, longint off, bit fixed, longint wre,
                              longint wim, logic [1:0] wst);
        vector_t v;
        v.req = '{mode, 32'(ar), 32'(ai), 32'(br), 32'(bi), 32'(off)};
        v.fixed = fixed;
        v.want = '{32'(wre), 32'(wim), wst};
        vectors.push_back(v);
    endtask

    task automatic send_request(vector_t v);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_payload <= v.req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        result_q.push_back(v.fixed ? v.want : alu_result(v.req));
    endtask

    initial begin
        int hold;
        @(posedge aresetn);
        forever begin
            hold = pick_gap();
            repeat (hold) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            repeat ($urandom_range(1, 8)) begin
                @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cau_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                report("unexpected result_re", m_payload.result_re, 0);
            end else begin
                want = result_q.pop_front();
                if (m_payload.result_re !== want.result_re)
                    report("result_re", m_payload.result_re, want.result_re);
                if (m_payload.result_im !== want.result_im)
                    report("result_im", m_payload.result_im, want.result_im);
                if (m_payload.status !== want.status)
                    report("status", m_payload.status, want.status);
            end
        end
    end

    initial begin
        vector_t v;
        add_vector(cau_pkg::MODE_ADD, 0, 0, 0, 0, 0, 1, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::MODE_ADD, S_MAX, 0, 1, 0, 0, 1, S_MAX, 0, cau_pkg::ST_SAT);
        add_vector(cau_pkg::MODE_SUB, S_MIN, S_MIN, 1, 1, 0, 1, S_MIN, S_MIN,
                   cau_pkg::ST_SAT);
        add_vector(cau_pkg::MODE_DIV, ONE, ONE, 0, 0, 0, 1, 0, 0, cau_pkg::ST_UNDEF);
        add_vector(cau_pkg::MODE_PHASE, 0, 0, ONE, ONE, ONE, 1, 0, 0, cau_pkg::ST_UNDEF);
        add_vector(3'd6, ONE, -ONE, ONE, 3, 7, 1, 0, 0, cau_pkg::ST_UNDEF);
        add_vector(3'd7, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, 1, 0, 0, cau_pkg::ST_UNDEF);
        add_vector(cau_pkg::MODE_MAG, ONE, 0, S_MAX, S_MIN, S_MAX, 1, ONE, 0,
                   cau_pkg::ST_OK);
        add_vector(cau_pkg::MODE_PHASE, ONE, 0, 5, 5, 0, 1, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::MODE_ADD, S_MIN, S_MAX, S_MIN, S_MAX, 0, 0, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::MODE_SUB, 3 * ONE, -ONE, ONE / 2, ONE, 0, 0, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::MODE_MUL, S_MIN, S_MIN, S_MIN, S_MIN, 0, 0, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::MODE_MUL, S_MAX, S_MAX, S_MAX, S_MIN, 0, 0, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::MODE_MUL, 3 * ONE / 2, -1, 5 * ONE / 2, 1, 0, 0, 0, 0,
                   cau_pkg::ST_OK);
        add_vector(cau_pkg::MODE_DIV, ONE, 0, -ONE, 0, 0, 0, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::MODE_DIV, S_MIN, S_MAX, 1, 0, 0, 0, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::MODE_DIV, 7, -3, S_MIN, S_MIN, 0, 0, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::MODE_MAG, S_MIN, S_MIN, 0, 0, 0, 0, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::MODE_PHASE, -ONE, 0, 0, 0, 0, 0, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::MODE_PHASE, 0, ONE, 0, 0, 0, 0, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::MODE_PHASE, 0, -ONE, 0, 0, 0, 0, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::MODE_PHASE, ONE, -1, 0, 0, 0, 0, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::MODE_PHASE, -5, 3, 0, 0, S_MAX, 0, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::MODE_PHASE, S_MIN, S_MIN, 0, 0, S_MIN, 0, 0, 0, cau_pkg::ST_OK);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (vectors[i]) send_request(vectors[i]);

        for (int n = 0; n < 800; n++) begin
            if (n % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            v.req.mode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                       : 3'($urandom_range(0, 5));
            v.req.a_re = pick_operand();
            v.req.a_im = pick_operand();
            v.req.b_re = pick_operand();
            v.req.b_im = pick_operand();
            v.req.phase_offset = pick_operand();
            v.fixed = 1'b0;
            v.want = '0;
            send_request(v);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        wait (result_q.size() == 0);
        repeat (60) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ complex_arithmetic_unit_top.f @@
hdl/cau_pkg.sv
hdl/complex_arithmetic_unit_top.sv
dv/complex_arithmetic_unit_top_tb.sv
